[hdl/rmth_pkg.sv]
// shared types, constants and helpers of the running median block
// no dependencies; compiled first
package rmth_pkg;

  localparam int DEF_CAPACITY    = 1024;
  localparam int DEF_SAMPLE_BITS = 32;

  // fixed widths of the word fields
  localparam int SAMPLE_W = 32;
  localparam int MEDIAN_W = 33;
  localparam int HELD_W   = 11;

  typedef enum logic {
    OP_PUSH,
    OP_MOVE
  } eng_op_t;

  typedef enum logic {
    HEAP_LOWER,
    HEAP_UPPER
  } heap_sel_t;

  typedef struct packed {
    logic      start;
    eng_op_t   op;
    heap_sel_t src;
  } eng_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } eng_stat_t;

  typedef enum logic [3:0] {
    E_IDLE,
    E_PUSH_UP,
    E_PUSH_CMP,
    E_POP_TOP,
    E_POP_LAST,
    E_POP_GET,
    E_DOWN_RL,
    E_DOWN_RR,
    E_DOWN_CMP
  } eng_state_t;

  typedef enum logic [2:0] {
    T_IDLE,
    T_PUSH,
    T_SWAP,
    T_BAL,
    T_EMIT
  } top_state_t;

  // heap order: max-heap for the lower half, min-heap for the upper half
  function automatic logic ahead(input logic signed [SAMPLE_W-1:0] a,
                                 input logic signed [SAMPLE_W-1:0] b,
                                 input heap_sel_t h);
    logic r;
    if (h == HEAP_UPPER) begin
      r = a < b;
    end else begin
      r = a > b;
    end
    return r;
  endfunction

endpackage

[hdl/rmth_in_if.sv]
// input channel: one sample word per handshake
// depends on rmth_pkg
interface rmth_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [rmth_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

[hdl/rmth_out_if.sv]
// result channel: median, count and overflow per word
// depends on rmth_pkg
interface rmth_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [rmth_pkg::MEDIAN_W-1:0] median_times_two;
  logic [rmth_pkg::HELD_W-1:0]          held_count;
  logic                                 overflow;

  modport source (output valid, output median_times_two, output held_count,
                  output overflow, input ready);
  modport sink   (input valid, input median_times_two, input held_count,
                  input overflow, output ready);
endinterface

[hdl/rmth_heap_engine.sv]
// two heap memories and the sift engine that pushes and moves elements
// depends on rmth_pkg
module rmth_heap_engine #(
  parameter int CAPACITY    = rmth_pkg::DEF_CAPACITY,
  parameter int SAMPLE_BITS = rmth_pkg::DEF_SAMPLE_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  rmth_pkg::eng_req_t          req,
  input  logic signed [SAMPLE_BITS-1:0] value,
  output rmth_pkg::eng_stat_t         stat,
  output logic [$clog2(CAPACITY/2+3)-1:0] lower_count,
  output logic [$clog2(CAPACITY/2+3)-1:0] upper_count,
  output logic signed [SAMPLE_BITS-1:0] lower_top,
  output logic signed [SAMPLE_BITS-1:0] upper_top
);
  import rmth_pkg::*;

  localparam int DEPTH = CAPACITY / 2 + 2;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int XW    = AW + 2;

  logic signed [SAMPLE_BITS-1:0] lmem [DEPTH];
  logic signed [SAMPLE_BITS-1:0] umem [DEPTH];
  logic signed [SAMPLE_BITS-1:0] lrd, urd, rdata;

  eng_state_t state, state_next;
  heap_sel_t  hsel, hsel_next;
  logic [AW-1:0] idx, idx_next;
  logic [CW-1:0] ncur, ncur_next;
  logic [CW-1:0] lcnt, lcnt_next, ucnt, ucnt_next, cnt_sel, cnt_oth;
  logic signed [SAMPLE_BITS-1:0] val, val_next, hold, hold_next, cl, cl_next;
  logic signed [SAMPLE_BITS-1:0] ltop, ltop_next, utop, utop_next;
  logic has_r, has_r_next, done, done_next;

  logic we;
  logic [AW-1:0] waddr, raddr, parent;
  logic signed [SAMPLE_BITS-1:0] wdata, best;
  logic [XW-1:0] lidx, ridx, nx, bidx;

  // memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (we && hsel == HEAP_LOWER) lmem[waddr] <= wdata;
    if (we && hsel == HEAP_UPPER) umem[waddr] <= wdata;
    lrd <= lmem[raddr];
    urd <= umem[raddr];
  end

  assign rdata   = (hsel == HEAP_UPPER) ? urd : lrd;
  assign cnt_sel = (hsel == HEAP_UPPER) ? ucnt : lcnt;
  assign cnt_oth = (hsel == HEAP_UPPER) ? lcnt : ucnt;
  assign parent  = (idx - AW'(1)) >> 1;
  assign lidx    = {1'b0, idx, 1'b1};
  assign ridx    = lidx + XW'(1);
  assign nx      = XW'(ncur);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
      lcnt  <= '0;
      ucnt  <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      lcnt  <= lcnt_next;
      ucnt  <= ucnt_next;
      done  <= done_next;
    end
    hsel  <= hsel_next;
    idx   <= idx_next;
    ncur  <= ncur_next;
    val   <= val_next;
    hold  <= hold_next;
    cl    <= cl_next;
    has_r <= has_r_next;
    ltop  <= ltop_next;
    utop  <= utop_next;
  end

  always_comb begin
    state_next = state;
    hsel_next  = hsel;
    idx_next   = idx;
    ncur_next  = ncur;
    lcnt_next  = lcnt;
    ucnt_next  = ucnt;
    val_next   = val;
    hold_next  = hold;
    cl_next    = cl;
    has_r_next = has_r;
    done_next  = 1'b0;
    we         = 1'b0;
    waddr      = idx;
    wdata      = val;
    raddr      = idx;
    best       = cl;
    bidx       = lidx;

    unique case (state)
      E_IDLE: begin
        if (req.start) begin
          if (req.op == OP_PUSH) begin
            hsel_next  = HEAP_LOWER;
            val_next   = value;
            idx_next   = AW'(lcnt);
            lcnt_next  = lcnt + CW'(1);
            state_next = E_PUSH_UP;
          end else begin
            hsel_next  = req.src;
            state_next = E_POP_TOP;
          end
        end
      end
      E_PUSH_UP: begin
        if (idx == '0) begin
          we         = 1'b1;
          done_next  = 1'b1;
          state_next = E_IDLE;
        end else begin
          raddr      = parent;
          state_next = E_PUSH_CMP;
        end
      end
      E_PUSH_CMP: begin
        we = 1'b1;
        if (ahead(SAMPLE_W'(val), SAMPLE_W'(rdata), hsel)) begin
          wdata      = rdata;
          idx_next   = parent;
          state_next = E_PUSH_UP;
        end else begin
          done_next  = 1'b1;
          state_next = E_IDLE;
        end
      end
      E_POP_TOP: begin
        hold_next = (hsel == HEAP_UPPER) ? utop : ltop;
        ncur_next = cnt_sel - CW'(1);
        if (hsel == HEAP_UPPER) ucnt_next = ucnt - CW'(1);
        else                    lcnt_next = lcnt - CW'(1);
        state_next = E_POP_LAST;
      end
      E_POP_LAST: begin
        if (ncur == '0) begin
          // heap emptied: go straight to the push into the other heap
          hsel_next  = (hsel == HEAP_UPPER) ? HEAP_LOWER : HEAP_UPPER;
          val_next   = hold;
          idx_next   = AW'(cnt_oth);
          if (hsel == HEAP_UPPER) lcnt_next = lcnt + CW'(1);
          else                    ucnt_next = ucnt + CW'(1);
          state_next = E_PUSH_UP;
        end else begin
          raddr      = AW'(ncur);
          state_next = E_POP_GET;
        end
      end
      E_POP_GET: begin
        val_next   = rdata;
        idx_next   = '0;
        state_next = E_DOWN_RL;
      end
      E_DOWN_RL: begin
        if (lidx >= nx) begin
          we         = 1'b1;
          hsel_next  = (hsel == HEAP_UPPER) ? HEAP_LOWER : HEAP_UPPER;
          val_next   = hold;
          idx_next   = AW'(cnt_oth);
          if (hsel == HEAP_UPPER) lcnt_next = lcnt + CW'(1);
          else                    ucnt_next = ucnt + CW'(1);
          state_next = E_PUSH_UP;
        end else begin
          raddr      = AW'(lidx);
          state_next = E_DOWN_RR;
        end
      end
      E_DOWN_RR: begin
        cl_next    = rdata;
        has_r_next = ridx < nx;
        raddr      = AW'(ridx);
        state_next = E_DOWN_CMP;
      end
      E_DOWN_CMP: begin
        if (has_r && ahead(SAMPLE_W'(rdata), SAMPLE_W'(cl), hsel)) begin
          best = rdata;
          bidx = ridx;
        end
        we = 1'b1;
        if (ahead(SAMPLE_W'(best), SAMPLE_W'(val), hsel)) begin
          wdata      = best;
          idx_next   = AW'(bidx);
          state_next = E_DOWN_RL;
        end else begin
          hsel_next  = (hsel == HEAP_UPPER) ? HEAP_LOWER : HEAP_UPPER;
          val_next   = hold;
          idx_next   = AW'(cnt_oth);
          if (hsel == HEAP_UPPER) lcnt_next = lcnt + CW'(1);
          else                    ucnt_next = ucnt + CW'(1);
          state_next = E_PUSH_UP;
        end
      end
      default: state_next = E_IDLE;
    endcase

    // mirror of each heap root
    ltop_next = ltop;
    utop_next = utop;
    if (we && waddr == '0) begin
      if (hsel == HEAP_UPPER) utop_next = wdata;
      else                    ltop_next = wdata;
    end
  end

  assign stat.busy   = (state != E_IDLE);
  assign stat.done   = done;
  assign lower_count = lcnt;
  assign upper_count = ucnt;
  assign lower_top   = ltop;
  assign upper_top   = utop;

endmodule

[hdl/running_median_two_heaps_core.sv]
// running median over two heaps: top level, sequencer and result register
// depends on rmth_pkg, rmth_in_if, rmth_out_if, rmth_heap_engine
//
//   channel     dir   handshake        payload
//   sample_ch   in    valid / ready    sample
//   result_ch   out   valid / ready    median_times_two, held_count, overflow
//
// one word at a time; a word needs one push and up to two moves, a move being
// a pop plus a push into the other heap; each heap memory has a single read port
// synchronous reset clears counts and control; memories need no clearing
// a result waits in the output register while the next sample is taken
module running_median_two_heaps_core #(
  parameter int CAPACITY    = rmth_pkg::DEF_CAPACITY,
  parameter int SAMPLE_BITS = rmth_pkg::DEF_SAMPLE_BITS
) (
  input logic         clk,
  input logic         rst,
  rmth_in_if.sink     sample_ch,
  rmth_out_if.source  result_ch
);
  import rmth_pkg::*;

  localparam int CW = $clog2(CAPACITY / 2 + 3);

  top_state_t state, state_next;
  eng_req_t   req;
  eng_stat_t  stat;
  logic [CW-1:0] lc, uc;
  logic signed [SAMPLE_BITS-1:0] ltop, utop, smp, smp_next;
  logic [CW:0] total;
  logic ovf, ovf_next;
  logic full, swap, l2u, u2l, slot_free, load, accept;
  logic signed [SAMPLE_BITS:0] med;

  // result register
  logic                       ovalid;
  logic signed [MEDIAN_W-1:0] med_r;
  logic [HELD_W-1:0]          held_r;
  logic                       ovf_r;

  rmth_heap_engine #(
    .CAPACITY    (CAPACITY),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .value       (smp),
    .stat        (stat),
    .lower_count (lc),
    .upper_count (uc),
    .lower_top   (ltop),
    .upper_top   (utop)
  );

  assign total     = {1'b0, lc} + {1'b0, uc};
  assign full      = 32'(total) >= CAPACITY;
  // lower root above upper root after the new sample
  assign swap      = (lc != '0) && (uc != '0) && (ltop > utop);
  // rebalance: lower holds as many as upper or one more
  assign l2u       = lc > (uc + CW'(1));
  assign u2l       = uc > lc;
  assign slot_free = !ovalid || result_ch.ready;
  assign accept    = sample_ch.valid && sample_ch.ready;

  // twice the median, exact
  always_comb begin
    if (lc > uc) begin
      med = {ltop, 1'b0};
    end else if (lc != '0 && uc != '0) begin
      med = (SAMPLE_BITS+1)'(ltop) + (SAMPLE_BITS+1)'(utop);
    end else begin
      med = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= T_IDLE;
      ovalid <= 1'b0;
    end else begin
      state <= state_next;
      if (load)                   ovalid <= 1'b1;
      else if (result_ch.ready)   ovalid <= 1'b0;
    end
    smp <= smp_next;
    ovf <= ovf_next;
    if (load) begin
      med_r  <= MEDIAN_W'(med);
      held_r <= HELD_W'(total);
      ovf_r  <= ovf;
    end
  end

  always_comb begin
    state_next      = state;
    smp_next        = smp;
    ovf_next        = ovf;
    req.start       = 1'b0;
    req.op          = OP_PUSH;
    req.src         = HEAP_LOWER;
    load            = 1'b0;
    sample_ch.ready = 1'b0;

    unique case (state)
      T_IDLE: begin
        sample_ch.ready = 1'b1;
        if (accept) begin
          smp_next = sample_ch.sample[SAMPLE_BITS-1:0];
          if (full) begin
            ovf_next   = 1'b1;
            state_next = T_EMIT;
          end else begin
            ovf_next   = 1'b0;
            state_next = T_PUSH;
          end
        end
      end
      T_PUSH: begin
        // first cycle after accept starts the push; then wait for done
        if (!stat.busy && !stat.done) begin
          req.start = 1'b1;
          req.op    = OP_PUSH;
        end else if (stat.done) begin
          if (swap) begin
            req.start  = 1'b1;
            req.op     = OP_MOVE;
            req.src    = HEAP_LOWER;
            state_next = T_SWAP;
          end else if (l2u || u2l) begin
            req.start  = 1'b1;
            req.op     = OP_MOVE;
            req.src    = l2u ? HEAP_LOWER : HEAP_UPPER;
            state_next = T_BAL;
          end else begin
            state_next = T_EMIT;
          end
        end
      end
      T_SWAP: begin
        if (stat.done) begin
          if (l2u || u2l) begin
            req.start  = 1'b1;
            req.op     = OP_MOVE;
            req.src    = l2u ? HEAP_LOWER : HEAP_UPPER;
            state_next = T_BAL;
          end else begin
            state_next = T_EMIT;
          end
        end
      end
      T_BAL: begin
        if (stat.done) state_next = T_EMIT;
      end
      T_EMIT: begin
        if (slot_free) begin
          load       = 1'b1;
          state_next = T_IDLE;
        end
      end
      default: state_next = T_IDLE;
    endcase
  end

  assign result_ch.valid            = ovalid;
  assign result_ch.median_times_two = med_r;
  assign result_ch.held_count       = held_r;
  assign result_ch.overflow         = ovf_r;

  // heaps stay balanced between words
  a_balance: assert property (@(posedge clk) disable iff (rst)
    (state == T_IDLE && !stat.busy) |-> (lc >= uc && lc <= uc + CW'(1)))
    else $error("heap counts out of balance");

  // engine only started while idle
  a_start: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !stat.busy)
    else $error("engine started while busy");

  // a dropped sample only happens with a full store
  a_ovf: assert property (@(posedge clk) disable iff (rst)
    (load && ovf) |-> full)
    else $error("overflow reported below capacity");

endmodule

[bench/running_median_two_heaps_core_test.sv]
`timescale 1ns / 100ps
// testbench for the running median block: samples in, checked medians out
// depends on rmth_pkg, rmth_in_if, rmth_out_if and running_median_two_heaps_core
module running_median_two_heaps_core_test;
  import rmth_pkg::*;

  localparam int CAP        = DEF_CAPACITY;
  localparam int HEAP_SLOTS = CAP / 2 + 2;
  localparam int IDLE_LIMIT = 6000;   // cycles with no word moving on either side
  localparam int DRAIN_WAIT = 200;    // one word's worth of heap work, with margin

  typedef struct {
    logic signed [MEDIAN_W-1:0] median;
    logic [HELD_W-1:0]          held;
    logic                       ovf;
  } median_word_t;

  // mirror of the two heaps; predicts one result word per accepted sample
  class median_scoreboard;
    int          heap [2][HEAP_SLOTS];
    int unsigned cnt [2];
    median_word_t awaited_q[$];
    int          errors;

    function automatic bit outranks(int a, int b, heap_sel_t h);
      return (h == HEAP_UPPER) ? (a < b) : (a > b);
    endfunction

    function automatic void heap_push(heap_sel_t h, int v);
      int unsigned i, p;
      int t;
      i = cnt[h];
      if (i >= HEAP_SLOTS) return;
      heap[h][i] = v;
      cnt[h] = i + 1;
      while (i > 0) begin
        p = (i - 1) / 2;
        if (!outranks(heap[h][i], heap[h][p], h)) break;
        t = heap[h][i]; heap[h][i] = heap[h][p]; heap[h][p] = t;
        i = p;
      end
    endfunction

    function automatic int heap_pop(heap_sel_t h);
      int unsigned n, i, l, r, best;
      int top, t;
      n = cnt[h];
      if (n == 0) return 0;
      top = heap[h][0];
      n--;
      heap[h][0] = heap[h][n];
      cnt[h] = n;
      i = 0;
      forever begin
        l = 2 * i + 1; r = l + 1; best = i;
        if (l < n && outranks(heap[h][l], heap[h][best], h)) best = l;
        if (r < n && outranks(heap[h][r], heap[h][best], h)) best = r;
        if (best == i) break;
        t = heap[h][i]; heap[h][i] = heap[h][best]; heap[h][best] = t;
        i = best;
      end
      return top;
    endfunction

    function automatic void note_sample(logic signed [SAMPLE_W-1:0] s);
      median_word_t w;
      longint m;
      w.ovf = 1'b0;
      if (cnt[HEAP_LOWER] + cnt[HEAP_UPPER] >= CAP) begin
        w.ovf = 1'b1;
      end else begin
        heap_push(HEAP_LOWER, int'(s));
        if (cnt[HEAP_LOWER] > 0 && cnt[HEAP_UPPER] > 0 &&
            heap[HEAP_LOWER][0] > heap[HEAP_UPPER][0])
          heap_push(HEAP_UPPER, heap_pop(HEAP_LOWER));
        if (cnt[HEAP_LOWER] > cnt[HEAP_UPPER] + 1)
          heap_push(HEAP_UPPER, heap_pop(HEAP_LOWER));
        else if (cnt[HEAP_UPPER] > cnt[HEAP_LOWER])
          heap_push(HEAP_LOWER, heap_pop(HEAP_UPPER));
      end
      m = 0;
      if (cnt[HEAP_LOWER] > cnt[HEAP_UPPER])
        m = 2 * longint'(heap[HEAP_LOWER][0]);
      else if (cnt[HEAP_LOWER] > 0 && cnt[HEAP_UPPER] > 0)
        m = longint'(heap[HEAP_LOWER][0]) + longint'(heap[HEAP_UPPER][0]);
      w.median = m[MEDIAN_W-1:0];
      w.held   = HELD_W'(cnt[HEAP_LOWER] + cnt[HEAP_UPPER]);
      awaited_q.push_back(w);
    endfunction

    function automatic void check_result(logic signed [MEDIAN_W-1:0] median,
                                         logic [HELD_W-1:0] held, logic ovf);
      median_word_t w;
      if (awaited_q.size() == 0) begin
        $error("result word with nothing awaited: median_times_two %0d", median);
        errors++;
        return;
      end
      w = awaited_q.pop_front();
      if (median !== w.median) begin
        $error("median_times_two: expected %0d, actual %0d", w.median, median);
        errors++;
      end
      if (held !== w.held) begin
        $error("held_count: expected %0d, actual %0d", w.held, held);
        errors++;
      end
      if (ovf !== w.ovf) begin
        $error("overflow: expected %0b, actual %0b", w.ovf, ovf);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  rmth_in_if  sample_ch ();
  rmth_out_if result_ch ();

  running_median_two_heaps_core dut (
    .clk       (clk),
    .rst       (rst),
    .sample_ch (sample_ch),
    .result_ch (result_ch)
  );

  always #6 clk = ~clk;

  median_scoreboard sb = new();

  // sender and receiver controls, set by the main sequence, and the watchdog count
  bit quiet     = 1'b0;  // no random idling in the final stretch
  int stall_req = 0;     // long hold-off requested on the result side
  int idle_cycles = 0;

  initial begin
    sample_ch.valid  = 1'b0;
    sample_ch.sample = '0;
    result_ch.ready  = 1'b0;
  end

  // result side: random ready bursts plus a long hold-off when the main sequence requests one
  initial begin
    int gap;
    @(negedge clk);
    forever begin
      if (stall_req > 0) begin
        gap = stall_req;
        stall_req = 0;
        result_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        result_ch.ready = 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end else begin
        result_ch.ready = 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
  end

  // check every accepted result word against the oldest prediction
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready)
      sb.check_result(result_ch.median_times_two, result_ch.held_count,
                      result_ch.overflow);
  end

  // watchdog: count cycles in which no word moves on either channel
  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) ||
        (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // offer one sample word, with an optional idle burst first
  task automatic send_sample(logic signed [SAMPLE_W-1:0] s);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      sample_ch.valid = 1'b0;
      repeat ($urandom_range(1, 7) - 1) @(negedge clk);
      @(negedge clk);
    end
    sample_ch.valid  = 1'b1;
    sample_ch.sample = s;
    do @(posedge clk); while (!sample_ch.ready);
    sb.note_sample(s);
  endtask

  // drop valid and wait until every predicted word has come back
  task automatic drain_results();
    @(negedge clk);
    sample_ch.valid = 1'b0;
    wait (sb.awaited_q.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // mix of full-range values, tight clusters with repeats, extremes and runs
  int run_val = 0;
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2:    return $signed($urandom_range(0, 16)) - 8;
      3:    return $urandom_range(0, 1) ? 32'sh7fff_ffff - $urandom_range(0, 3)
                                        : 32'sh8000_0000 + $urandom_range(0, 3);
      4: begin
        run_val = run_val + $urandom_range(0, 5);
        return run_val;
      end
      default: return $signed($urandom_range(0, 2000)) - 1000;
    endcase
  endfunction

  initial begin
    logic signed [SAMPLE_W-1:0] directed [$];
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: extremes, sign boundaries, duplicates, ascending and descending order
    directed = '{32'sh7fff_ffff, 32'sh8000_0000, 0, -1, 1, 32'sh7fff_ffff,
                 32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 5, 5, 5,
                 10, 20, 30, 40, -10, -20, -30, -40, 32'sh5555_5555, 32'shaaaa_aaaa};
    foreach (directed[i]) send_sample(directed[i]);
    drain_results();

    // random phase with a long result-side hold-off so the block backs up
    for (int i = 0; i < 500; i++) begin
      if (i == 50) stall_req = 500;
      send_sample(pick_sample());
    end
    // sender pauses until every result is back
    drain_results();

    // fills the store to capacity, then keeps going into the overflow region
    for (int i = 0; i < 700; i++) send_sample(pick_sample());
    drain_results();

    // final stretch without idling on either side
    quiet = 1'b1;
    for (int i = 0; i < 430; i++) send_sample(pick_sample());
    drain_results();

    if (sb.errors == 0 && sb.awaited_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[running_median_two_heaps_core.f]
hdl/rmth_pkg.sv
hdl/rmth_in_if.sv
hdl/rmth_out_if.sv
hdl/rmth_heap_engine.sv
hdl/running_median_two_heaps_core.sv
bench/running_median_two_heaps_core_test.sv
